>>> hw/rtl/tpad_pkg.sv
`default_nettype none

package tpad_pkg;

    // default delay / counter width
    localparam int DELAY_BITS_DEF = 14;

    // register reset values
    localparam int ZERO_DELAY_RST    = 7000;
    localparam int DELAY_SPAN_RST    = 6200;
    localparam int FULL_ON_DELAY_RST = 800;
    localparam int PULSE_TICKS_RST   = 20;

    // only the low 14 bits of a delay register write are kept
    localparam int CFG_DELAY_MASK = 16'h3FFF;

    // register indexes
    localparam logic [1:0] REG_ZERO_DELAY    = 2'd0;
    localparam logic [1:0] REG_DELAY_SPAN    = 2'd1;
    localparam logic [1:0] REG_FULL_ON_DELAY = 2'd2;
    localparam logic [1:0] REG_PULSE_TICKS   = 2'd3;

    // action codes
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_ZERO  = 3'd1;
    localparam logic [2:0] ACT_LEVEL = 3'd2;
    localparam logic [2:0] ACT_ON    = 3'd3;
    localparam logic [2:0] ACT_OFF   = 3'd4;

    // level scaling
    localparam logic [6:0] PCT_MAX   = 7'd100;
    localparam int         LEVEL_DIV = 100;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] percent;
    } in_t;

    typedef struct packed {
        logic        gate;
        logic        busy_res;
        logic        enabled;
        logic [13:0] delay_now;
    } out_t;

    // one slot of the level pipeline
    typedef struct packed {
        logic valid;
        in_t  item;
    } lvl_stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/tpad_cfg.sv
`default_nettype none

module tpad_cfg #(
    parameter int DB = tpad_pkg::DELAY_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [DB-1:0] cfg_data,
    output logic      [DB-1:0] zero_delay,
    output logic      [DB-1:0] delay_span,
    output logic      [DB-1:0] full_on_delay,
    output logic      [7:0]    pulse_ticks
);
    import tpad_pkg::*;

    logic [DB-1:0] zero_delay_reg;
    logic [DB-1:0] delay_span_reg;
    logic [DB-1:0] full_on_delay_reg;
    logic [7:0]    pulse_ticks_reg;
    logic [DB-1:0] wdata_delay;

    assign wdata_delay = cfg_data & DB'(CFG_DELAY_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_delay_reg    <= DB'(ZERO_DELAY_RST);
            delay_span_reg    <= DB'(DELAY_SPAN_RST);
            full_on_delay_reg <= DB'(FULL_ON_DELAY_RST);
            pulse_ticks_reg   <= 8'(PULSE_TICKS_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ZERO_DELAY:    zero_delay_reg    <= wdata_delay;
                REG_DELAY_SPAN:    delay_span_reg    <= wdata_delay;
                REG_FULL_ON_DELAY: full_on_delay_reg <= wdata_delay;
                REG_PULSE_TICKS:   pulse_ticks_reg   <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    assign zero_delay    = zero_delay_reg;
    assign delay_span    = delay_span_reg;
    assign full_on_delay = full_on_delay_reg;
    assign pulse_ticks   = pulse_ticks_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tpad_level.sv
`default_nettype none

module tpad_level #(
    parameter int DB = tpad_pkg::DELAY_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire tpad_pkg::in_t        in_data,
    input  wire logic [DB-1:0]        zero_delay,
    input  wire logic [DB-1:0]        delay_span,
    output tpad_pkg::lvl_stage_t      s3,
    output logic      [DB-1:0]        level_delay
);
    import tpad_pkg::*;

    localparam int PROD_W = DB + 7;
    localparam int K      = PROD_W + 7;
    localparam int MW     = 2 * PROD_W + 1;
    // floor(2^K / 100): estimate is exact or one low for any product
    localparam longint unsigned RECIP = (64'd1 << K) / LEVEL_DIV;

    lvl_stage_t        s1_reg, s2_reg, s3_reg;
    logic [PROD_W-1:0] s1_prod_reg, s2_prod_reg;
    logic [DB-1:0]     s2_qest_reg;
    logic [DB-1:0]     s3_cut_reg;

    logic [6:0]        pct_sat;
    logic [PROD_W-1:0] prod;
    logic [MW-1:0]     mult;
    logic [PROD_W-1:0] rem;
    logic [DB-1:0]     cut;

    // stage 1: span * saturated percent
    assign pct_sat = (in_data.percent > PCT_MAX) ? PCT_MAX : in_data.percent;
    assign prod    = PROD_W'(delay_span) * PROD_W'(pct_sat);

    // stage 2: reciprocal multiply
    assign mult = MW'(s1_prod_reg) * MW'(RECIP);

    // stage 3: one-step correction of the quotient
    assign rem = s2_prod_reg - PROD_W'(s2_qest_reg) * PROD_W'(LEVEL_DIV);
    assign cut = (rem >= PROD_W'(LEVEL_DIV)) ? s2_qest_reg + 1'b1 : s2_qest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg.valid <= in_valid;
            s1_reg.item  <= in_data;
            s2_reg       <= s1_reg;
            s3_reg       <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg <= prod;
            s2_prod_reg <= s1_prod_reg;
            s2_qest_reg <= mult[K +: DB];
            s3_cut_reg  <= cut;
        end
    end

    assign s3          = s3_reg;
    // negative delay saturates at zero
    assign level_delay = (s3_cut_reg >= zero_delay) ? '0 : zero_delay - s3_cut_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tpad_fire.sv
`default_nettype none

module tpad_fire #(
    parameter int DB = tpad_pkg::DELAY_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire tpad_pkg::lvl_stage_t s3,
    input  wire logic [DB-1:0]        level_delay,
    input  wire logic [DB-1:0]        full_on_delay,
    input  wire logic [7:0]           pulse_ticks,
    output logic                      out_valid,
    output tpad_pkg::out_t            out_data
);
    import tpad_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DELAY = 2'd1;
    localparam logic [1:0] PH_PULSE = 2'd2;

    logic [DB-1:0] firing_delay_reg, firing_delay_next;
    logic          firing_enabled_reg, firing_enabled_next;
    logic [1:0]    phase_reg, phase_next;
    logic [DB-1:0] tick_count_reg, tick_count_next;
    logic          gate_level_reg, gate_level_next;
    logic          out_valid_reg;
    out_t          out_data_reg;
    logic          step;
    logic          cnt_last;

    assign step     = adv && s3.valid;
    assign cnt_last = (tick_count_reg <= DB'(1));

    always_comb
    begin
        firing_delay_next   = firing_delay_reg;
        firing_enabled_next = firing_enabled_reg;
        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        gate_level_next     = gate_level_reg;
        if (phase_reg != PH_DELAY && phase_reg != PH_PULSE)
            phase_next = PH_IDLE;
        unique case (s3.item.action)
            ACT_TICK:
            begin
                unique case (phase_reg)
                    PH_DELAY:
                    begin
                        if (cnt_last)
                        begin
                            gate_level_next = 1'b1;
                            phase_next      = PH_PULSE;
                            tick_count_next = DB'(pulse_ticks);
                        end
                        else
                            tick_count_next = tick_count_reg - 1'b1;
                    end
                    PH_PULSE:
                    begin
                        if (cnt_last)
                        begin
                            gate_level_next = 1'b0;
                            phase_next      = PH_IDLE;
                            tick_count_next = '0;
                        end
                        else
                            tick_count_next = tick_count_reg - 1'b1;
                    end
                    default: ;
                endcase
            end
            ACT_ZERO:
            begin
                if (firing_enabled_reg && phase_reg != PH_DELAY && phase_reg != PH_PULSE)
                begin
                    phase_next      = PH_DELAY;
                    tick_count_next = firing_delay_reg;
                end
            end
            ACT_LEVEL:
            begin
                firing_delay_next   = level_delay;
                firing_enabled_next = 1'b1;
            end
            ACT_ON:
            begin
                firing_delay_next   = full_on_delay;
                firing_enabled_next = 1'b1;
                gate_level_next     = 1'b1;
            end
            ACT_OFF:
            begin
                // an in-flight delay or pulse phase keeps running; the gate drops at once
                firing_enabled_next = 1'b0;
                gate_level_next     = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            firing_delay_reg   <= '0;
            firing_enabled_reg <= 1'b0;
            phase_reg          <= PH_IDLE;
            tick_count_reg     <= '0;
            gate_level_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                firing_delay_reg   <= firing_delay_next;
                firing_enabled_reg <= firing_enabled_next;
                phase_reg          <= phase_next;
                tick_count_reg     <= tick_count_next;
                gate_level_reg     <= gate_level_next;
            end
            if (adv)
                out_valid_reg <= s3.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.gate      <= gate_level_next;
            out_data_reg.busy_res  <= (phase_next != PH_IDLE);
            out_data_reg.enabled   <= firing_enabled_next;
            out_data_reg.delay_now <= 14'(firing_delay_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/triac_phase_angle_dimmer_core.sv
`default_nettype none
// Triac phase-angle dimmer core.
// Four register stages: three level-math stages, the last one feeding the state and
// result registers.
// Throughput: one transaction per cycle; the whole pipeline holds only on an output stall.
// Reset: rst_n asynchronous, active low; clears pipeline valids, dimmer state and loads
// register defaults (zero_delay 7000, delay_span 6200, full_on_delay 800, pulse_ticks 20).

module triac_phase_angle_dimmer_core #(
    parameter int DELAY_BITS = tpad_pkg::DELAY_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire tpad_pkg::in_t         in_data,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output tpad_pkg::out_t             out_data,
    // register write port
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [DELAY_BITS-1:0] cfg_data
);
    import tpad_pkg::*;

    logic [DELAY_BITS-1:0] zero_delay;
    logic [DELAY_BITS-1:0] delay_span;
    logic [DELAY_BITS-1:0] full_on_delay;
    logic [7:0]            pulse_ticks;
    logic [DELAY_BITS-1:0] level_delay;
    lvl_stage_t            s3;
    logic                  adv;

    // The pipeline moves as one: every stage advances unless a finished result
    // sits in the output register and the consumer stalls. The output register
    // acts as the slot that parts the two sides, so a new transaction is taken
    // in the same cycle the previous result is taken.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    tpad_cfg #(
        .DB(DELAY_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .zero_delay    (zero_delay),
        .delay_span    (delay_span),
        .full_on_delay (full_on_delay),
        .pulse_ticks   (pulse_ticks)
    );

    // Level math: delay = zero_delay - floor(span * pct / 100), saturated at 0.
    // The divide by 100 is a reciprocal multiply plus one correction step.
    // None of it depends on dimmer state, so it runs ahead of the state stage.
    tpad_level #(
        .DB(DELAY_BITS)
    ) u_level (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .zero_delay  (zero_delay),
        .delay_span  (delay_span),
        .s3          (s3),
        .level_delay (level_delay)
    );

    // State stage: phase sequencer (idle / delay count / gate pulse), enable,
    // firing delay, gate level; registers one result per transaction.
    tpad_fire #(
        .DB(DELAY_BITS)
    ) u_fire (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .s3            (s3),
        .level_delay   (level_delay),
        .full_on_delay (full_on_delay),
        .pulse_ticks   (pulse_ticks),
        .out_valid     (out_valid),
        .out_data      (out_data)
    );

endmodule

`default_nettype wire
